### rtl/assert_macros.svh
// Assertion macros used by the parser top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while the active-low reset rstn is released.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/wspp_pkg.sv
`timescale 1ns / 1ps

package wspp_pkg;

    // Packet length limits.
    localparam int BASIC_LEN = 17;
    localparam int FULL_LEN  = 21;

    // Byte positions within a packet.
    localparam int POS_W            = 5;
    localparam int POS_HEADER       = 0;
    localparam int POS_FIRST_CHECK  = 16;
    localparam int POS_SECOND_FIRST = 17;
    localparam int POS_SECOND_LAST  = 19;
    localparam int POS_SECOND_CHECK = 20;
    localparam int POS_MAX          = 31;

    // Capture store: packet bytes 2 to 19.
    localparam int CAP_FIRST = 2;
    localparam int CAP_DEPTH = 18;

    // Header register.
    localparam logic [7:0] HEADER_RESET = 8'h24;
    localparam logic       REG_HEADER   = 1'b0;

    // Packet status codes.
    localparam logic [1:0] STATUS_INVALID = 2'd0;
    localparam logic [1:0] STATUS_BASIC   = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef logic [CAP_DEPTH-1:0][7:0] cap_array_t;

    // Laid out so that the packed value is the result tdata word (last field lowest).
    typedef struct packed {
        logic [1:0]  pad;
        logic [23:0] pressure_hundredths;
        logic [23:0] light_code;
        logic [15:0] uv_code;
        logic [15:0] rain_count;
        logic [7:0]  wind_gust_code;
        logic [8:0]  wind_speed_code;
        logic [7:0]  humidity_pct;
        logic [10:0] temperature_code;
        logic [8:0]  wind_direction_deg;
        logic        battery_low;
    } result_t;

endpackage

### rtl/wspp_unpack.sv
`timescale 1ns / 1ps

// Assembles the sensor fields from the captured packet bytes.
// Store entry k holds packet byte k+2.
module wspp_unpack (
    input  wspp_pkg::cap_array_t cap_bytes,
    input  logic [1:0]           status,
    output wspp_pkg::result_t    result
);

    logic [7:0] flags;

    assign flags = cap_bytes[1];    // packet byte 3 carries the high bits and the battery flag

    always_comb begin
        result = '0;
        if (status != wspp_pkg::STATUS_INVALID) begin
            result.battery_low        = flags[3];
            result.wind_direction_deg = {flags[7], cap_bytes[0]};
            result.temperature_code   = {flags[2:0], cap_bytes[2]};
            result.humidity_pct       = cap_bytes[3];
            result.wind_speed_code    = {flags[4], cap_bytes[4]};
            result.wind_gust_code     = cap_bytes[5];
            result.rain_count         = {cap_bytes[6], cap_bytes[7]};
            result.uv_code            = {cap_bytes[8], cap_bytes[9]};
            result.light_code         = {cap_bytes[10], cap_bytes[11], cap_bytes[12]};
            if (status == wspp_pkg::STATUS_FULL) begin
                result.pressure_hundredths = {cap_bytes[15], cap_bytes[16], cap_bytes[17]};
            end
        end
    end

endmodule

### rtl/weather_station_packet_parser_top.sv
`timescale 1ns / 1ps
// Channel   | Direction | Transaction carries
// ----------+-----------+--------------------------------------------------------------
// s_axis    | in        | one packet byte (tdata[7:0]), tlast on the final byte
// m_axis    | out       | one decoded packet: tuser = status, tdata = sensor fields
// apb       | in        | header byte register at byte address 0
//
// One byte is taken in each cycle unless the output stalls. All decoding happens in
// the cycle that the byte is accepted, between the packet state registers and the
// result register. A result appears on the master side in the cycle after its
// final byte is accepted. The result register is the only buffering: while it
// holds an untaken result, bytes are still accepted if the result is taken in that
// same cycle. aresetn is synchronous and active low; it clears the packet state,
// the result valid flag and sets the header register to 0x24.
`include "assert_macros.svh"

module weather_station_packet_parser_top (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // last_byte

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] battery_low, [9:1] wind_direction_deg, [20:10] temperature_code,
    // [28:21] humidity_pct, [37:29] wind_speed_code, [45:38] wind_gust_code,
    // [61:46] rain_count, [77:62] uv_code, [101:78] light_code,
    // [125:102] pressure_hundredths, [127:126] zero
    output logic [127:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] packet_status

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int PW = wspp_pkg::POS_W;

    // Configuration register.
    logic [7:0] header_reg;

    // Packet state.
    logic [PW-1:0]        byte_pos_reg, byte_pos_next;
    logic [7:0]           first_sum_reg, first_sum_next;
    logic [7:0]           second_sum_reg, second_sum_next;
    logic                 header_ok_reg, header_ok_next;
    logic                 first_ok_reg, first_ok_next;
    wspp_pkg::cap_array_t cap_reg;

    // Result register.
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg;
    wspp_pkg::result_t    m_result_reg;

    logic                 s_accept;
    logic                 cap_en;
    logic [PW-1:0]        cap_idx;
    logic [1:0]           status;
    wspp_pkg::result_t    result;
    logic                 apb_write;

    // APB side. Only word 0 exists; writes elsewhere are dropped.
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == wspp_pkg::REG_HEADER) ? {24'd0, header_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= wspp_pkg::HEADER_RESET;
        end else if (apb_write && paddr[2] == wspp_pkg::REG_HEADER) begin
            header_reg <= pwdata[7:0];
        end
    end

    // A byte may enter whenever the result register is free or is emptied this cycle.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Running checks. The next values already include the current byte, so the
    // status of a packet whose final byte is this one is judged from them.
    always_comb begin
        header_ok_next  = header_ok_reg;
        first_sum_next  = first_sum_reg;
        first_ok_next   = first_ok_reg;
        second_sum_next = second_sum_reg;

        if (byte_pos_reg == PW'(wspp_pkg::POS_HEADER)) begin
            header_ok_next = (s_axis_tdata == header_reg);
        end
        if (byte_pos_reg < PW'(wspp_pkg::POS_FIRST_CHECK)) begin
            first_sum_next = first_sum_reg + s_axis_tdata;
        end
        if (byte_pos_reg == PW'(wspp_pkg::POS_FIRST_CHECK)) begin
            first_ok_next = (first_sum_reg == s_axis_tdata);
        end
        if (byte_pos_reg >= PW'(wspp_pkg::POS_SECOND_FIRST) &&
            byte_pos_reg <= PW'(wspp_pkg::POS_SECOND_LAST)) begin
            second_sum_next = second_sum_reg + s_axis_tdata;
        end
        // A zero after this XOR means the pressure checksum matched.
        if (byte_pos_reg == PW'(wspp_pkg::POS_SECOND_CHECK)) begin
            second_sum_next = second_sum_reg ^ s_axis_tdata;
        end

        // The counter stops at its top value on over-long packets.
        if (byte_pos_reg != PW'(wspp_pkg::POS_MAX)) begin
            byte_pos_next = byte_pos_reg + PW'(1);
        end else begin
            byte_pos_next = byte_pos_reg;
        end
    end

    // Packet length is position plus one, so the length limits compare against position.
    always_comb begin
        status = wspp_pkg::STATUS_INVALID;
        if (byte_pos_reg >= PW'(wspp_pkg::BASIC_LEN - 1) && header_ok_next && first_ok_next) begin
            if (byte_pos_reg >= PW'(wspp_pkg::FULL_LEN - 1) && second_sum_next == 8'd0) begin
                status = wspp_pkg::STATUS_FULL;
            end else begin
                status = wspp_pkg::STATUS_BASIC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg   <= '0;
            first_sum_reg  <= '0;
            second_sum_reg <= '0;
            header_ok_reg  <= 1'b0;
            first_ok_reg   <= 1'b0;
        end else if (s_accept) begin
            if (s_axis_tlast) begin
                byte_pos_reg   <= '0;
                first_sum_reg  <= '0;
                second_sum_reg <= '0;
                header_ok_reg  <= 1'b0;
                first_ok_reg   <= 1'b0;
            end else begin
                byte_pos_reg   <= byte_pos_next;
                first_sum_reg  <= first_sum_next;
                second_sum_reg <= second_sum_next;
                header_ok_reg  <= header_ok_next;
                first_ok_reg   <= first_ok_next;
            end
        end
    end

    // Capture store for packet bytes 2 to 19. The fields read for a valid result
    // always come from bytes written earlier in the same packet.
    assign cap_idx = byte_pos_reg - PW'(wspp_pkg::CAP_FIRST);
    assign cap_en  = s_accept &&
                     byte_pos_reg >= PW'(wspp_pkg::CAP_FIRST) &&
                     byte_pos_reg <  PW'(wspp_pkg::CAP_FIRST + wspp_pkg::CAP_DEPTH);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < wspp_pkg::CAP_DEPTH; i++) begin
            if (cap_en && cap_idx == PW'(i)) begin
                cap_reg[i] <= s_axis_tdata;
            end
        end
    end

    wspp_unpack u_unpack (
        .cap_bytes (cap_reg),
        .status    (status),
        .result    (result)
    );

    // Result register: loaded by a final byte, emptied when the sink takes it.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept && s_axis_tlast) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_axis_tlast) begin
            m_status_reg <= status;
            m_result_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = m_result_reg;

    `ASSERT_CLKD(a_last_restarts_packet, aclk, aresetn,
        s_accept && s_axis_tlast |=> byte_pos_reg == '0 && !header_ok_reg && !first_ok_reg,
        "packet state not cleared after final byte")

    `ASSERT_CLKD(a_last_gives_result, aclk, aresetn,
        s_accept && s_axis_tlast |=> m_axis_tvalid,
        "final byte accepted but no result presented")

    `ASSERT_CLKD(a_status_code_legal, aclk, aresetn,
        m_axis_tvalid |-> (m_axis_tuser == wspp_pkg::STATUS_INVALID ||
                           m_axis_tuser == wspp_pkg::STATUS_BASIC ||
                           m_axis_tuser == wspp_pkg::STATUS_FULL),
        "result carries an unknown packet status")

    `ASSERT_CLKD(a_invalid_is_blank, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser == wspp_pkg::STATUS_INVALID |-> m_axis_tdata == '0,
        "invalid packet result carries sensor data")

    `ASSERT_CLKD(a_pressure_only_full, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser != wspp_pkg::STATUS_FULL
            |-> m_result_reg.pressure_hundredths == '0,
        "pressure reported without a verified pressure block")

endmodule
